FILE: hdl/rrcb_pkg.sv
// shared constants, types and functions of the rotated rectangle corner block
package rrcb_pkg;

  // coordinate format, signed q.4
  localparam int COORD_WIDTH   = 20;
  localparam int CORDIC_STAGES = 16;

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH - 1;

  // angle in 1/64 degree
  localparam int ANG_W  = 16;
  localparam int ANG_SH = 16;

  // cordic datapath
  localparam int ATAN_COUNT = 24;
  localparam int NUM_STAGES = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STAGES;
  localparam int SI_W       = $clog2(ATAN_COUNT);
  localparam int X_W        = 32;
  localparam int Z_W        = 31;

  localparam logic signed [X_W-1:0] GAIN_Q30 = 32'sd652032874;

  // products, sums and rounded offsets
  localparam int P_W    = X_W + DW + 1;
  localparam int SUM_W  = P_W + 1;
  localparam int RND_SH = 31;
  localparam int O_W    = SUM_W - RND_SH;
  localparam int E_W    = O_W + 1;

  typedef struct packed {
    logic signed [CW-1:0]    center_x;
    logic signed [CW-1:0]    center_y;
    logic        [DW-1:0]    rect_width;
    logic        [DW-1:0]    rect_height;
    logic signed [ANG_W-1:0] rotation_angle;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_link_t;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic                  neg;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic        [DW-1:0]  w;
    logic        [DW-1:0]  h;
  } cordic_t;

  typedef struct packed {
    logic    valid;
    cordic_t data;
  } cordic_link_t;

  typedef struct packed {
    logic signed [CW-1:0] corner0_x;
    logic signed [CW-1:0] corner0_y;
    logic signed [CW-1:0] corner1_x;
    logic signed [CW-1:0] corner1_y;
    logic signed [CW-1:0] corner2_x;
    logic signed [CW-1:0] corner2_y;
    logic signed [CW-1:0] corner3_x;
    logic signed [CW-1:0] corner3_y;
    logic signed [CW-1:0] box_left;
    logic signed [CW-1:0] box_top;
    logic signed [CW-1:0] box_right;
    logic signed [CW-1:0] box_bottom;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t item;
  } out_link_t;

  // atan(2^-i) in 2^-22 degree, rounded to nearest
  function automatic logic [Z_W-1:0] atan_at(input logic [SI_W-1:0] idx);
    logic [Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = Z_W'(188743680);
      5'd1:    v = Z_W'(111421900);
      5'd2:    v = Z_W'(58872272);
      5'd3:    v = Z_W'(29884485);
      5'd4:    v = Z_W'(15000234);
      5'd5:    v = Z_W'(7507429);
      5'd6:    v = Z_W'(3754631);
      5'd7:    v = Z_W'(1877430);
      5'd8:    v = Z_W'(938729);
      5'd9:    v = Z_W'(469366);
      5'd10:   v = Z_W'(234683);
      5'd11:   v = Z_W'(117342);
      5'd12:   v = Z_W'(58671);
      5'd13:   v = Z_W'(29335);
      5'd14:   v = Z_W'(14668);
      5'd15:   v = Z_W'(7334);
      5'd16:   v = Z_W'(3667);
      5'd17:   v = Z_W'(1833);
      5'd18:   v = Z_W'(917);
      5'd19:   v = Z_W'(458);
      5'd20:   v = Z_W'(229);
      5'd21:   v = Z_W'(115);
      5'd22:   v = Z_W'(57);
      5'd23:   v = Z_W'(29);
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp a widened coordinate to the signed coordinate range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [E_W-1:0] v);
    logic signed [E_W-1:0] hi;
    logic signed [E_W-1:0] lo;
    logic signed [CW-1:0]  r;
    hi = {{(E_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = {{(E_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
    if (v > hi) begin
      r = hi[CW-1:0];
    end else if (v < lo) begin
      r = lo[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/rrcb_if.sv
// request and result stream interfaces of the rotated rectangle corner block
interface rrcb_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rrcb_pkg::CW-1:0]        center_x;
  logic signed [rrcb_pkg::CW-1:0]        center_y;
  logic        [rrcb_pkg::DW-1:0]        rect_width;
  logic        [rrcb_pkg::DW-1:0]        rect_height;
  logic signed [rrcb_pkg::ANG_W-1:0]     rotation_angle;

  modport source (
    output valid, center_x, center_y, rect_width, rect_height, rotation_angle,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, rect_width, rect_height, rotation_angle,
    output ready
  );
endinterface

interface rrcb_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [rrcb_pkg::CW-1:0] corner0_x;
  logic signed [rrcb_pkg::CW-1:0] corner0_y;
  logic signed [rrcb_pkg::CW-1:0] corner1_x;
  logic signed [rrcb_pkg::CW-1:0] corner1_y;
  logic signed [rrcb_pkg::CW-1:0] corner2_x;
  logic signed [rrcb_pkg::CW-1:0] corner2_y;
  logic signed [rrcb_pkg::CW-1:0] corner3_x;
  logic signed [rrcb_pkg::CW-1:0] corner3_y;
  logic signed [rrcb_pkg::CW-1:0] box_left;
  logic signed [rrcb_pkg::CW-1:0] box_top;
  logic signed [rrcb_pkg::CW-1:0] box_right;
  logic signed [rrcb_pkg::CW-1:0] box_bottom;

  modport source (
    output valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
           corner3_x, corner3_y, box_left, box_top, box_right, box_bottom,
    input  ready
  );
  modport sink (
    input  valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
           corner3_x, corner3_y, box_left, box_top, box_right, box_bottom,
    output ready
  );
endinterface

FILE: hdl/rrcb_angle_prep.sv
// angle reduction to plus or minus 90 degrees and cordic seed register
module rrcb_angle_prep (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrcb_pkg::in_link_t     up_i,
  output logic                   up_ready_o,
  output rrcb_pkg::cordic_link_t dn_o,
  input  logic                   dn_ready_i
);

  localparam int AR_W = rrcb_pkg::ANG_W + 1;
  localparam logic signed [AR_W-1:0] ANG_FULL    = AR_W'(23040);
  localparam logic signed [AR_W-1:0] ANG_HALF    = AR_W'(11520);
  localparam logic signed [AR_W-1:0] ANG_QUARTER = AR_W'(5760);

  logic                  valid_q;
  rrcb_pkg::cordic_t     data_q;
  rrcb_pkg::cordic_t     data_d;

  always_comb begin
    logic signed [AR_W-1:0] n;
    logic signed [AR_W-1:0] r;
    logic signed [AR_W-1:0] t;
    logic                   neg;
    logic [AR_W+rrcb_pkg::ANG_SH-1:0] zcat;
    n = -$signed({up_i.item.rotation_angle[rrcb_pkg::ANG_W-1], up_i.item.rotation_angle});
    // wrap into one full turn
    r = n;
    if (n < 0) begin
      r = n + ANG_FULL;
      if (r < 0) begin
        r = r + ANG_FULL;
      end
    end else if (n >= ANG_FULL) begin
      r = n - ANG_FULL;
    end
    t = (r >= ANG_HALF) ? (r - ANG_FULL) : r;
    // fold into the right half plane, flipping both outputs
    neg = 1'b0;
    if (t > ANG_QUARTER) begin
      t   = t - ANG_HALF;
      neg = 1'b1;
    end else if (t < -ANG_QUARTER) begin
      t   = t + ANG_HALF;
      neg = 1'b1;
    end
    zcat = {t, {rrcb_pkg::ANG_SH{1'b0}}};
    data_d.x   = rrcb_pkg::GAIN_Q30;
    data_d.y   = '0;
    data_d.z   = zcat[rrcb_pkg::Z_W-1:0];
    data_d.neg = neg;
    data_d.cx  = up_i.item.center_x;
    data_d.cy  = up_i.item.center_y;
    data_d.w   = up_i.item.rect_width;
    data_d.h   = up_i.item.rect_height;
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_i.valid) begin
      data_q <= data_d;
    end
  end

  assign dn_o.valid = valid_q;
  assign dn_o.data  = data_q;

endmodule

FILE: hdl/rrcb_cordic_cell.sv
// one cordic rotation cell with its own pipeline register
module rrcb_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rrcb_pkg::SI_W-1:0]   stage_i,
  input  rrcb_pkg::cordic_link_t      up_i,
  output logic                        up_ready_o,
  output rrcb_pkg::cordic_link_t      dn_o,
  input  logic                        dn_ready_i
);

  logic              valid_q;
  rrcb_pkg::cordic_t data_q;
  rrcb_pkg::cordic_t data_d;

  always_comb begin
    logic signed [rrcb_pkg::X_W-1:0] dx;
    logic signed [rrcb_pkg::X_W-1:0] dy;
    logic signed [rrcb_pkg::Z_W-1:0] da;
    dx = up_i.data.y >>> stage_i;
    dy = up_i.data.x >>> stage_i;
    da = $signed(rrcb_pkg::atan_at(stage_i));
    data_d = up_i.data;
    // residual not negative: rotate forward
    if (!up_i.data.z[rrcb_pkg::Z_W-1]) begin
      data_d.x = up_i.data.x - dx;
      data_d.y = up_i.data.y + dy;
      data_d.z = up_i.data.z - da;
    end else begin
      data_d.x = up_i.data.x + dx;
      data_d.y = up_i.data.y - dy;
      data_d.z = up_i.data.z + da;
    end
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_i.valid) begin
      data_q <= data_d;
    end
  end

  assign dn_o.valid = valid_q;
  assign dn_o.data  = data_q;

endmodule

FILE: hdl/rrcb_corner_calc.sv
// sign fix, products, rounded offsets, saturated corners and bounding box
module rrcb_corner_calc (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrcb_pkg::cordic_link_t up_i,
  output logic                   up_ready_o,
  output rrcb_pkg::out_link_t    dn_o,
  input  logic                   dn_ready_i
);

  localparam int CW    = rrcb_pkg::CW;
  localparam int X_W   = rrcb_pkg::X_W;
  localparam int P_W   = rrcb_pkg::P_W;
  localparam int SUM_W = rrcb_pkg::SUM_W;
  localparam int O_W   = rrcb_pkg::O_W;
  localparam int E_W   = rrcb_pkg::E_W;

  typedef struct packed {
    logic signed [X_W-1:0]      s;
    logic signed [X_W-1:0]      c;
    logic signed [CW-1:0]       cx;
    logic signed [CW-1:0]       cy;
    logic [rrcb_pkg::DW-1:0]    w;
    logic [rrcb_pkg::DW-1:0]    h;
  } trig_t;

  typedef struct packed {
    logic signed [P_W-1:0] p_sh;
    logic signed [P_W-1:0] p_cw;
    logic signed [P_W-1:0] p_ch;
    logic signed [P_W-1:0] p_sw;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
  } prod_t;

  typedef struct packed {
    logic signed [O_W-1:0] o0x;
    logic signed [O_W-1:0] o0y;
    logic signed [O_W-1:0] o3x;
    logic signed [O_W-1:0] o3y;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
  } offs_t;

  typedef struct packed {
    logic [3:0][CW-1:0] px;
    logic [3:0][CW-1:0] py;
  } corner_t;

  logic    v0_q, v1_q, v2_q, v3_q, v4_q;
  logic    r0, r1, r2, r3, r4;
  trig_t   trig_q, trig_d;
  prod_t   prod_q, prod_d;
  offs_t   offs_q, offs_d;
  corner_t corn_q, corn_d;
  rrcb_pkg::result_t res_q, res_d;

  function automatic logic signed [O_W-1:0] round_q4(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = v + (SUM_W'(1) <<< (rrcb_pkg::RND_SH - 1));
    return t[SUM_W-1:rrcb_pkg::RND_SH];
  endfunction

  function automatic logic signed [CW-1:0] min2(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [CW-1:0] max2(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (b > a) ? b : a;
  endfunction

  // ready ripples back from the output register
  assign r4 = !v4_q || dn_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign r0 = !v0_q || r1;
  assign up_ready_o = r0;

  // sign fix for folded angles
  always_comb begin
    trig_d.s  = up_i.data.neg ? -up_i.data.y : up_i.data.y;
    trig_d.c  = up_i.data.neg ? -up_i.data.x : up_i.data.x;
    trig_d.cx = up_i.data.cx;
    trig_d.cy = up_i.data.cy;
    trig_d.w  = up_i.data.w;
    trig_d.h  = up_i.data.h;
  end

  // four products in q34
  always_comb begin
    logic signed [rrcb_pkg::DW:0] hs;
    logic signed [rrcb_pkg::DW:0] ws;
    hs = $signed({1'b0, trig_q.h});
    ws = $signed({1'b0, trig_q.w});
    prod_d.p_sh = P_W'(trig_q.s) * P_W'(hs);
    prod_d.p_cw = P_W'(trig_q.c) * P_W'(ws);
    prod_d.p_ch = P_W'(trig_q.c) * P_W'(hs);
    prod_d.p_sw = P_W'(trig_q.s) * P_W'(ws);
    prod_d.cx   = trig_q.cx;
    prod_d.cy   = trig_q.cy;
  end

  // offsets rounded half up to q4
  always_comb begin
    logic signed [SUM_W-1:0] sh, cw_p, ch, sw;
    sh   = SUM_W'(prod_q.p_sh);
    cw_p = SUM_W'(prod_q.p_cw);
    ch   = SUM_W'(prod_q.p_ch);
    sw   = SUM_W'(prod_q.p_sw);
    offs_d.o0x = round_q4(sh - cw_p);
    offs_d.o0y = round_q4(-ch - sw);
    offs_d.o3x = round_q4(-sh - cw_p);
    offs_d.o3y = round_q4(ch - sw);
    offs_d.cx  = prod_q.cx;
    offs_d.cy  = prod_q.cy;
  end

  // corners, reflections taken before saturation
  always_comb begin
    logic signed [E_W-1:0] cx, cy, o0x, o0y, o3x, o3y;
    cx  = E_W'(offs_q.cx);
    cy  = E_W'(offs_q.cy);
    o0x = E_W'(offs_q.o0x);
    o0y = E_W'(offs_q.o0y);
    o3x = E_W'(offs_q.o3x);
    o3y = E_W'(offs_q.o3y);
    corn_d.px[0] = rrcb_pkg::sat_coord(cx + o0x);
    corn_d.py[0] = rrcb_pkg::sat_coord(cy + o0y);
    corn_d.px[2] = rrcb_pkg::sat_coord(cx - o0x);
    corn_d.py[2] = rrcb_pkg::sat_coord(cy - o0y);
    corn_d.px[3] = rrcb_pkg::sat_coord(cx + o3x);
    corn_d.py[3] = rrcb_pkg::sat_coord(cy + o3y);
    corn_d.px[1] = rrcb_pkg::sat_coord(cx - o3x);
    corn_d.py[1] = rrcb_pkg::sat_coord(cy - o3y);
  end

  // bounding box over the saturated corners
  always_comb begin
    logic signed [CW-1:0] x0, x1, x2, x3, y0, y1, y2, y3;
    x0 = $signed(corn_q.px[0]);
    x1 = $signed(corn_q.px[1]);
    x2 = $signed(corn_q.px[2]);
    x3 = $signed(corn_q.px[3]);
    y0 = $signed(corn_q.py[0]);
    y1 = $signed(corn_q.py[1]);
    y2 = $signed(corn_q.py[2]);
    y3 = $signed(corn_q.py[3]);
    res_d.corner0_x  = x0;
    res_d.corner0_y  = y0;
    res_d.corner1_x  = x1;
    res_d.corner1_y  = y1;
    res_d.corner2_x  = x2;
    res_d.corner2_y  = y2;
    res_d.corner3_x  = x3;
    res_d.corner3_y  = y3;
    res_d.box_left   = min2(min2(x0, x1), min2(x2, x3));
    res_d.box_top    = min2(min2(y0, y1), min2(y2, y3));
    res_d.box_right  = max2(max2(x0, x1), max2(x2, x3));
    res_d.box_bottom = max2(max2(y0, y1), max2(y2, y3));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r0) v0_q <= up_i.valid;
      if (r1) v1_q <= v0_q;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r0 && up_i.valid) trig_q <= trig_d;
    if (r1 && v0_q)       prod_q <= prod_d;
    if (r2 && v1_q)       offs_q <= offs_d;
    if (r3 && v2_q)       corn_q <= corn_d;
    if (r4 && v3_q)       res_q  <= res_d;
  end

  assign dn_o.valid = v4_q;
  assign dn_o.item  = res_q;

endmodule

FILE: hdl/rotated_rect_corners_bbox.sv
// top level of the rotated rectangle corner and bounding box block
// takes one rectangle request per cycle and returns its four corners and
// axis-aligned box through 1 + NUM_STAGES + 5 register stages; the rate of
// one request per clock, while results are taken, is set by the row of
// cordic cells, one rotation per cell, and every stage holds its own valid
// bit so a stalled result only stops the stages behind it while empty
// stages keep filling; coordinates are signed q.4 and saturate per corner,
// the angle is counter-clockwise in 1/64 degree and wraps at a full turn
module rotated_rect_corners_bbox (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrcb_in_if.sink     req_i,
  rrcb_out_if.source  res_o
);

  localparam int NS = rrcb_pkg::NUM_STAGES;

  rrcb_pkg::in_link_t     in_link;
  rrcb_pkg::cordic_link_t chain    [NS+1];
  logic                   chain_rdy[NS+1];
  rrcb_pkg::out_link_t    out_link;

  // pack the request channel
  assign in_link.valid               = req_i.valid;
  assign in_link.item.center_x       = req_i.center_x;
  assign in_link.item.center_y       = req_i.center_y;
  assign in_link.item.rect_width     = req_i.rect_width;
  assign in_link.item.rect_height    = req_i.rect_height;
  assign in_link.item.rotation_angle = req_i.rotation_angle;

  // negate and fold the angle, seed the rotation with the cordic gain
  rrcb_angle_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_i       (in_link),
    .up_ready_o (req_i.ready),
    .dn_o       (chain[0]),
    .dn_ready_i (chain_rdy[0])
  );

  // row of cordic cells, cell k rotates by atan(2^-k)
  for (genvar k = 0; k < NS; k++) begin : g_cell
    rrcb_cordic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .stage_i    (rrcb_pkg::SI_W'(k)),
      .up_i       (chain[k]),
      .up_ready_o (chain_rdy[k]),
      .dn_o       (chain[k+1]),
      .dn_ready_i (chain_rdy[k+1])
    );
  end

  // sine and cosine to corners and box, last stage is the output register
  rrcb_corner_calc u_corner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_i       (chain[NS]),
    .up_ready_o (chain_rdy[NS]),
    .dn_o       (out_link),
    .dn_ready_i (res_o.ready)
  );

  // unpack the result channel
  assign res_o.valid      = out_link.valid;
  assign res_o.corner0_x  = out_link.item.corner0_x;
  assign res_o.corner0_y  = out_link.item.corner0_y;
  assign res_o.corner1_x  = out_link.item.corner1_x;
  assign res_o.corner1_y  = out_link.item.corner1_y;
  assign res_o.corner2_x  = out_link.item.corner2_x;
  assign res_o.corner2_y  = out_link.item.corner2_y;
  assign res_o.corner3_x  = out_link.item.corner3_x;
  assign res_o.corner3_y  = out_link.item.corner3_y;
  assign res_o.box_left   = out_link.item.box_left;
  assign res_o.box_top    = out_link.item.box_top;
  assign res_o.box_right  = out_link.item.box_right;
  assign res_o.box_bottom = out_link.item.box_bottom;

endmodule
